// ===== sv/pmts_pkg.sv =====
// ----------------------------------------------------------------------------
// pmts_pkg: shared types and constants for per-month temperature statistics
// Widths, action and report codes, controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pmts_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int NUM_BINS    = 12;
   localparam int BIN_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   localparam int MONTH_W     = 4;
   localparam int TEMP_W      = 8;
   localparam int OUT_CNT_W   = 16;
   localparam int AVG_W       = 12;
   localparam int SUM_W       = 24;
   localparam int FRAC_W      = 4;
   localparam int QUO_W       = 12;
   localparam int STEP_W      = 4;
   localparam int TOT_W       = ((COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W) + 4;
   localparam int ACC_W       = 17;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 20;
   localparam int RECIP       = ((2 ** RECIP_SHIFT) + NUM_BINS - 1) / NUM_BINS;

   localparam logic signed [TEMP_W-1:0] INIT_MIN = 8'sd99;
   localparam logic signed [TEMP_W-1:0] INIT_MAX = -8'sd99;

   localparam logic [1:0] ACT_RECORD = 2'd0;
   localparam logic [1:0] ACT_MONTH  = 2'd1;
   localparam logic [1:0] ACT_YEAR   = 2'd2;

   localparam logic REPORT_MONTH = 1'b0;
   localparam logic REPORT_YEAR  = 1'b1;

   typedef struct packed {
      logic capture;
      logic record;
      logic bin_load;
      logic bin_next;
      logic div_load;
      logic div_step;
      logic accum;
      logic ymul;
      logic out_load;
   } pmts_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       in_bin;
      logic       bin_last;
      logic       div_last;
      logic       out_busy;
   } pmts_stat_type;

   function automatic logic [OUT_CNT_W-1:0] sat16(input logic [TOT_W-1:0] v);
      logic [TOT_W-1:0] lim;
      lim = TOT_W'({OUT_CNT_W{1'b1}});
      return (v > lim) ? {OUT_CNT_W{1'b1}} : v[OUT_CNT_W-1:0];
   endfunction

endpackage

// ===== sv/pmts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmts_ctrl: sequencing state machine
// Accepts one word at a time, dispatches records and walks the divider
// over one bin or all bins for reports.
// ----------------------------------------------------------------------------
module pmts_ctrl
   import pmts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  pmts_stat_type stat,
   output pmts_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_DIV_END,
      S_YMUL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.action)
               ACT_RECORD: begin
                  cmd.record = 1'b1;
                  state_in   = S_IDLE;
               end
               ACT_MONTH: begin
                  if (stat.in_bin) begin
                     cmd.bin_load = 1'b1;
                     state_in     = S_DIV_LOAD;
                  end else begin
                     state_in = S_OUT;
                  end
               end
               ACT_YEAR: begin
                  cmd.bin_load = 1'b1;
                  state_in     = S_DIV_LOAD;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            if (stat.action == ACT_MONTH) begin
               state_in = S_OUT;
            end else begin
               cmd.accum = 1'b1;
               if (stat.bin_last) begin
                  state_in = S_YMUL;
               end else begin
                  cmd.bin_next = 1'b1;
                  state_in     = S_DIV_LOAD;
               end
            end
         end
         S_YMUL: begin
            cmd.ymul = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_tready = ready_ff;

endmodule

// ===== sv/pmts_dp.sv =====
// ----------------------------------------------------------------------------
// pmts_dp: statistics datapath
// Per-bin counters and extremes, year extremes, bit-serial mean divider,
// year accumulator with reciprocal divide, and the result register.
// ----------------------------------------------------------------------------
module pmts_dp
   import pmts_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  pmts_cmd_type             cmd,
   output pmts_stat_type            stat,
   input  logic [1:0]               req_action,
   input  logic [MONTH_W-1:0]       req_month,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic                     req_row_ok,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic                     rsp_report_kind,
   output logic [MONTH_W-1:0]       rsp_report_month,
   output logic [OUT_CNT_W-1:0]     rsp_total_rows,
   output logic [OUT_CNT_W-1:0]     rsp_valid_rows,
   output logic [OUT_CNT_W-1:0]     rsp_error_rows,
   output logic [AVG_W-1:0]         rsp_average_q4,
   output logic [TEMP_W-1:0]        rsp_temp_high,
   output logic [TEMP_W-1:0]        rsp_temp_low
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [SUM_W-1:0]       SUM_HI  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]       SUM_LO  = {1'b1, {(SUM_W-1){1'b0}}};

   // bin storage
   logic [COUNT_WIDTH-1:0]   row_cnt_ff   [NUM_BINS];
   logic [COUNT_WIDTH-1:0]   valid_cnt_ff [NUM_BINS];
   logic [SUM_W-1:0]         sum_ff       [NUM_BINS];
   logic signed [TEMP_W-1:0] min_ff       [NUM_BINS];
   logic signed [TEMP_W-1:0] max_ff       [NUM_BINS];
   logic signed [TEMP_W-1:0] year_min_ff, year_max_ff;

   // captured word
   logic [1:0]               cap_action_ff;
   logic [MONTH_W-1:0]       cap_month_ff;
   logic signed [TEMP_W-1:0] cap_temp_ff;
   logic                     cap_ok_ff;

   logic [BIN_W-1:0]         bin_ff;

   // divider
   logic [COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   den_ff;
   logic                     neg_ff;
   logic [STEP_W-1:0]        step_ff;

   // year accumulation
   logic signed [ACC_W-1:0]  acc_ff;
   logic [TOT_W-1:0]         tot_ff, val_ff;
   logic [QUO_W-1:0]         yq_ff, yq_in;
   logic                     yneg_ff;

   logic                     rsp_valid_ff;

   // record path
   logic                     in_bin;
   logic [BIN_W-1:0]         rec_idx;
   logic [COUNT_WIDTH-1:0]   row_cur, row_in, vc_cur, vc_in;
   logic [SUM_W-1:0]         sum_cur, sum_in;
   logic signed [SUM_W:0]    sum_wide;

   assign in_bin  = (cap_month_ff != '0) &&
                    ({1'b0, cap_month_ff} <= (MONTH_W+1)'(NUM_BINS));
   assign rec_idx = BIN_W'(cap_month_ff - MONTH_W'(1));
   assign row_cur = row_cnt_ff[rec_idx];
   assign vc_cur  = valid_cnt_ff[rec_idx];
   assign sum_cur = sum_ff[rec_idx];
   assign row_in  = (row_cur != CNT_MAX) ? row_cur + 1'b1 : row_cur;
   assign vc_in   = vc_cur + 1'b1;
   assign sum_wide = $signed({sum_cur[SUM_W-1], sum_cur}) +
                     $signed({{(SUM_W+1-TEMP_W){cap_temp_ff[TEMP_W-1]}}, cap_temp_ff});

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? SUM_LO : SUM_HI;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            row_cnt_ff[i]   <= '0;
            valid_cnt_ff[i] <= '0;
            sum_ff[i]       <= '0;
            min_ff[i]       <= INIT_MIN;
            max_ff[i]       <= INIT_MAX;
         end
         year_min_ff <= INIT_MIN;
         year_max_ff <= INIT_MAX;
      end else if (cmd.record) begin
         if (in_bin) row_cnt_ff[rec_idx] <= row_in;
         if (cap_ok_ff) begin
            if (cap_temp_ff < year_min_ff) year_min_ff <= cap_temp_ff;
            if (cap_temp_ff > year_max_ff) year_max_ff <= cap_temp_ff;
            if (in_bin) begin
               if (vc_cur != CNT_MAX) begin
                  valid_cnt_ff[rec_idx] <= vc_in;
                  sum_ff[rec_idx]       <= sum_in;
               end
               if (cap_temp_ff < min_ff[rec_idx]) min_ff[rec_idx] <= cap_temp_ff;
               if (cap_temp_ff > max_ff[rec_idx]) max_ff[rec_idx] <= cap_temp_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_action_ff <= req_action;
         cap_month_ff  <= req_month;
         cap_temp_ff   <= req_temperature;
         cap_ok_ff     <= req_row_ok;
      end
   end

   // bin walk and year accumulation
   logic [SUM_W-1:0]             div_sum;
   logic [SUM_W-1:0]             div_mag;
   logic [SUM_W+FRAC_W-1:0]      div_num;
   logic [QUO_W-1:0]             mean_mag;
   logic signed [QUO_W:0]        mean_s;
   logic [ACC_W-1:0]             acc_mag;
   logic [ACC_W+RECIP_W-1:0]     prod;

   assign div_sum  = sum_ff[bin_ff];
   assign div_mag  = div_sum[SUM_W-1] ? (~div_sum + 1'b1) : div_sum;
   assign div_num  = {div_mag, {FRAC_W{1'b0}}};
   assign mean_mag = (den_ff == '0) ? '0 : quo_ff;
   assign mean_s   = neg_ff ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});
   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign prod     = acc_mag * RECIP_W'(RECIP);
   assign yq_in    = prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.bin_load) begin
         bin_ff <= (cap_action_ff == ACT_YEAR) ? '0 : rec_idx;
         acc_ff <= '0;
         tot_ff <= '0;
         val_ff <= '0;
      end else begin
         if (cmd.bin_next) bin_ff <= bin_ff + 1'b1;
         if (cmd.accum) begin
            acc_ff <= acc_ff + ACC_W'(mean_s);
            tot_ff <= tot_ff + TOT_W'(row_cnt_ff[bin_ff]);
            val_ff <= val_ff + TOT_W'(valid_cnt_ff[bin_ff]);
         end
      end
      if (cmd.ymul) begin
         yq_ff   <= yq_in;
         yneg_ff <= acc_ff[ACC_W-1];
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [COUNT_WIDTH:0] trial, trial_diff;
   logic                 trial_ge;

   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign trial_ge   = (trial >= {1'b0, den_ff});
   assign rem_in     = trial_ge ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
   assign quo_in     = {quo_ff[QUO_W-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= COUNT_WIDTH'(div_num[SUM_W+FRAC_W-1:QUO_W]);
         quo_ff  <= div_num[QUO_W-1:0];
         den_ff  <= valid_cnt_ff[bin_ff];
         neg_ff  <= div_sum[SUM_W-1];
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff + 1'b1;
      end
   end

   // result register
   logic [OUT_CNT_W-1:0]  o_tot, o_val;
   logic [AVG_W-1:0]      o_avg;
   logic [TEMP_W-1:0]     o_high, o_low;
   logic signed [QUO_W:0] yavg_s;
   logic                  rpt_kind_ff;
   logic [MONTH_W-1:0]    rpt_month_ff;
   logic [OUT_CNT_W-1:0]  rpt_total_ff, rpt_valid_ff, rpt_error_ff;
   logic [AVG_W-1:0]      rpt_avg_ff;
   logic [TEMP_W-1:0]     rpt_high_ff, rpt_low_ff;

   assign yavg_s = yneg_ff ? -$signed({1'b0, yq_ff}) : $signed({1'b0, yq_ff});

   always_comb begin
      if (cap_action_ff == ACT_YEAR) begin
         o_tot  = sat16(tot_ff);
         o_val  = sat16(val_ff);
         o_avg  = yavg_s[AVG_W-1:0];
         o_high = year_max_ff;
         o_low  = year_min_ff;
      end else if (in_bin) begin
         o_tot  = sat16(TOT_W'(row_cnt_ff[bin_ff]));
         o_val  = sat16(TOT_W'(valid_cnt_ff[bin_ff]));
         o_avg  = mean_s[AVG_W-1:0];
         o_high = max_ff[bin_ff];
         o_low  = min_ff[bin_ff];
      end else begin
         o_tot  = '0;
         o_val  = '0;
         o_avg  = '0;
         o_high = INIT_MAX;
         o_low  = INIT_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rpt_kind_ff  <= (cap_action_ff == ACT_YEAR) ? REPORT_YEAR : REPORT_MONTH;
         rpt_month_ff <= (cap_action_ff == ACT_YEAR) ? '0 : cap_month_ff;
         rpt_total_ff <= o_tot;
         rpt_valid_ff <= o_val;
         rpt_error_ff <= (o_tot >= o_val) ? o_tot - o_val : '0;
         rpt_avg_ff   <= o_avg;
         rpt_high_ff  <= o_high;
         rpt_low_ff   <= o_low;
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_report_kind  = rpt_kind_ff;
   assign rsp_report_month = rpt_month_ff;
   assign rsp_total_rows   = rpt_total_ff;
   assign rsp_valid_rows   = rpt_valid_ff;
   assign rsp_error_rows   = rpt_error_ff;
   assign rsp_average_q4   = rpt_avg_ff;
   assign rsp_temp_high    = rpt_high_ff;
   assign rsp_temp_low     = rpt_low_ff;

   assign stat.action   = cap_action_ff;
   assign stat.in_bin   = in_bin;
   assign stat.bin_last = (bin_ff == BIN_W'(NUM_BINS - 1));
   assign stat.div_last = (step_ff == STEP_W'(QUO_W - 1));
   assign stat.out_busy = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("result register overwritten while pending");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && den_ff != '0 |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

   a_year_order: assert property (@(posedge clock) disable iff (reset)
      cmd.record && cap_ok_ff |=> year_min_ff <= year_max_ff)
      else $error("year extremes out of order after good row");

endmodule

// ===== sv/per_month_temperature_statistics_core.sv =====
// ----------------------------------------------------------------------------
// per_month_temperature_statistics_core: binned temperature statistics
// Record rows into twelve monthly bins; report a month or the whole year.
// Record: no result; ready again once the word is dispatched.
// Month report: mean from a 12-step serial divider; a month outside 1..12
// skips the divider.
// Year report: the divider walks all twelve bins, then a reciprocal divide.
// One word in flight at a time; a pending result stalls only the next report.
// Synchronous reset clears all bins, extremes and handshake state.
// ----------------------------------------------------------------------------
module per_month_temperature_statistics_core
   import pmts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // month[3:0], temperature[11:4], row_ok[12]
   input  logic [1:0]  req_tuser,  // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // report_month[3:0], total_rows[19:4],
                                   // valid_rows[35:20], error_rows[51:36],
                                   // average_q4[63:52], temp_high[71:64],
                                   // temp_low[79:72]
   output logic        rsp_tuser   // report_kind[0]
);

   pmts_cmd_type         cmd;
   pmts_stat_type        stat;
   logic [MONTH_W-1:0]   o_month;
   logic [OUT_CNT_W-1:0] o_tot, o_val, o_err;
   logic [AVG_W-1:0]     o_avg;
   logic [TEMP_W-1:0]    o_high, o_low;

   pmts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pmts_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_tuser),
      .req_month        (req_tdata[3:0]),
      .req_temperature  (req_tdata[11:4]),
      .req_row_ok       (req_tdata[12]),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_report_kind  (rsp_tuser),
      .rsp_report_month (o_month),
      .rsp_total_rows   (o_tot),
      .rsp_valid_rows   (o_val),
      .rsp_error_rows   (o_err),
      .rsp_average_q4   (o_avg),
      .rsp_temp_high    (o_high),
      .rsp_temp_low     (o_low)
   );

   assign rsp_tdata = {o_low, o_high, o_avg, o_err, o_val, o_tot, o_month};

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for per_month_temperature_statistics_core
// Drives record, month-report, year-report and unused words with random gaps
// on both streams. A local copy of the bin statistics predicts each report,
// and every report word is compared field by field in arrival order.
// Covered: empty bins, out-of-range months, error rows and extremes at the
// initial bounds.
// ----------------------------------------------------------------------------
module testbench
   import pmts_pkg::*;
();

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 250;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam longint SUM_HI = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LO = -(longint'(1) <<< (SUM_W - 1));
   localparam longint OUT_MAX = 65535;

   typedef struct packed {
      logic [2:0]               pad;
      logic                     row_ok;
      logic signed [TEMP_W-1:0] temperature;
      logic [MONTH_W-1:0]       month;
   } row_word_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_low;
      logic signed [TEMP_W-1:0] temp_high;
      logic signed [AVG_W-1:0]  average_q4;
      logic [OUT_CNT_W-1:0]     error_rows;
      logic [OUT_CNT_W-1:0]     valid_rows;
      logic [OUT_CNT_W-1:0]     total_rows;
      logic [MONTH_W-1:0]       report_month;
   } report_body_type;

   typedef struct {
      logic [1:0]   action;
      row_word_type fields;
      bit           drain;
   } word_item_type;

   typedef struct {
      logic            kind;
      report_body_type body;
   } report_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // month[3:0], temperature[11:4], row_ok[12]
   logic [1:0]  req_tuser = '0;  // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;       // report_month[3:0], total_rows[19:4],
                                 // valid_rows[35:20], error_rows[51:36],
                                 // average_q4[63:52], temp_high[71:64],
                                 // temp_low[79:72]
   logic        rsp_tuser;       // report_kind[0]

   per_month_temperature_statistics_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   logic [COUNT_WIDTH-1:0]   bin_rows [NUM_BINS];
   logic [COUNT_WIDTH-1:0]   bin_good [NUM_BINS];
   logic signed [SUM_W-1:0]  bin_sum  [NUM_BINS];
   logic signed [TEMP_W-1:0] bin_low  [NUM_BINS];
   logic signed [TEMP_W-1:0] bin_high [NUM_BINS];
   logic signed [TEMP_W-1:0] year_low;
   logic signed [TEMP_W-1:0] year_high;

   word_item_type   pending_words[$];
   report_type      expected_reports[$];
   word_item_type   cur_word;
   report_type      want;
   report_body_type got;

   int issued_cnt;
   int reports_total = 0;
   int words_accepted = 0;
   int words_total = 0;
   int results_seen = 0;
   int mismatches = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(15, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic signed [TEMP_W-1:0] rnd_temp();
      if ($urandom_range(9) < 7) return TEMP_W'($urandom_range(75) - 30);
      return TEMP_W'($urandom_range(255));
   endfunction

   function automatic logic [MONTH_W-1:0] rnd_month();
      if ($urandom_range(9) != 0) return MONTH_W'($urandom_range(NUM_BINS, 1));
      if ($urandom_range(3) == 0) return '0;
      return MONTH_W'($urandom_range(15, NUM_BINS + 1));
   endfunction

   function automatic longint clip16(longint v);
      return (v > OUT_MAX) ? OUT_MAX : v;
   endfunction

   function automatic logic signed [AVG_W-1:0] month_mean(int b);
      longint s;
      longint n;
      if (bin_good[b] == 0) return '0;
      s = bin_sum[b];
      n = bin_good[b];
      return AVG_W'((s * 16) / n);
   endfunction

   task automatic clear_stats();
      for (int b = 0; b < NUM_BINS; b++) begin
         bin_rows[b] = '0;
         bin_good[b] = '0;
         bin_sum[b] = '0;
         bin_low[b] = INIT_MIN;
         bin_high[b] = INIT_MAX;
      end
      year_low = INIT_MIN;
      year_high = INIT_MAX;
      issued_cnt = 0;
      expected_reports.delete();
   endtask

   task automatic update_stats(input word_item_type w);
      int b;
      logic in_bin;
      logic signed [TEMP_W-1:0] t;
      longint s;
      longint tot;
      longint val;
      longint acc;
      report_type r;
      bit emits;
      in_bin = (w.fields.month >= 1) && (w.fields.month <= NUM_BINS);
      b = in_bin ? int'(w.fields.month) - 1 : 0;
      t = w.fields.temperature;
      emits = 1'b0;
      tot = 0;
      val = 0;
      r.body = '0;
      case (w.action)
         ACT_RECORD: begin
            if (in_bin && bin_rows[b] != COUNT_MAX) bin_rows[b] = bin_rows[b] + 1'b1;
            if (w.fields.row_ok) begin
               if (t < year_low) year_low = t;
               if (t > year_high) year_high = t;
               if (in_bin) begin
                  if (bin_good[b] != COUNT_MAX) begin
                     bin_good[b] = bin_good[b] + 1'b1;
                     s = longint'(bin_sum[b]) + longint'(t);
                     if (s > SUM_HI) s = SUM_HI;
                     else if (s < SUM_LO) s = SUM_LO;
                     bin_sum[b] = SUM_W'(s);
                  end
                  if (t < bin_low[b]) bin_low[b] = t;
                  if (t > bin_high[b]) bin_high[b] = t;
               end
            end
         end
         ACT_MONTH: begin
            emits = 1'b1;
            r.kind = REPORT_MONTH;
            r.body.report_month = w.fields.month;
            if (in_bin) begin
               tot = bin_rows[b];
               val = bin_good[b];
               r.body.average_q4 = month_mean(b);
               r.body.temp_high = bin_high[b];
               r.body.temp_low = bin_low[b];
            end else begin
               r.body.average_q4 = '0;
               r.body.temp_high = INIT_MAX;
               r.body.temp_low = INIT_MIN;
            end
         end
         ACT_YEAR: begin
            emits = 1'b1;
            acc = 0;
            for (int i = 0; i < NUM_BINS; i++) begin
               tot += bin_rows[i];
               val += bin_good[i];
               acc += month_mean(i);
            end
            r.kind = REPORT_YEAR;
            r.body.report_month = '0;
            r.body.average_q4 = AVG_W'(acc / NUM_BINS);
            r.body.temp_high = year_high;
            r.body.temp_low = year_low;
         end
         default: ;
      endcase
      if (emits) begin
         r.body.total_rows = OUT_CNT_W'(clip16(tot));
         r.body.valid_rows = OUT_CNT_W'(clip16(val));
         r.body.error_rows = OUT_CNT_W'(clip16(tot) - clip16(val));
         expected_reports.push_back(r);
         issued_cnt++;
      end
   endtask

   task automatic push_word(logic [1:0] act, logic [MONTH_W-1:0] mon,
                            logic signed [TEMP_W-1:0] temp, logic ok,
                            bit drain = 1'b0);
      word_item_type w;
      w.action = act;
      w.fields.pad = '0;
      w.fields.row_ok = ok;
      w.fields.temperature = temp;
      w.fields.month = mon;
      w.drain = drain;
      pending_words.push_back(w);
      words_total++;
   endtask

   task automatic check_field(string name, longint expd, longint actual);
      if (expd != actual) begin
         $error("%s: expected %0d, actual %0d", name, expd, actual);
         mismatches++;
      end
   endtask

   // driver: offer pending words, predict each accepted word
   always @(posedge clock) begin
      if (reset) begin
         clear_stats();
         req_tvalid <= 1'b0;
         send_gap <= 0;
         words_accepted <= 0;
         reports_total <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_stats(cur_word);
            words_accepted <= words_accepted + 1;
            reports_total <= issued_cnt;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].drain && issued_cnt != results_seen)) begin
               cur_word = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= cur_word.fields;
               req_tuser <= cur_word.action;
               send_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // hold off the report stream once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         stall_done <= 1'b0;
      end else if (!stall_done && words_accepted >= 600) begin
         stall_left <= 600;
         stall_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // monitor: compare each report word with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap <= 0;
         results_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report word: kind %0d data %h", rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               got = rsp_tdata;
               check_field("report_kind", want.kind, rsp_tuser);
               check_field("report_month", want.body.report_month, got.report_month);
               check_field("total_rows", want.body.total_rows, got.total_rows);
               check_field("valid_rows", want.body.valid_rows, got.valid_rows);
               check_field("error_rows", want.body.error_rows, got.error_rows);
               check_field("average_q4", want.body.average_q4, got.average_q4);
               check_field("temp_high", want.body.temp_high, got.temp_high);
               check_field("temp_low", want.body.temp_low, got.temp_low);
               results_seen <= results_seen + 1;
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int r;
      push_word(ACT_YEAR, 4'd0, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd1, 8'sd0, 1'b0);
      push_word(ACT_RECORD, 4'd15, 8'sd126, 1'b1);
      push_word(ACT_RECORD, 4'd0, -8'sd127, 1'b1);
      push_word(ACT_RECORD, 4'd13, 8'sd5, 1'b0);
      push_word(ACT_YEAR, 4'd15, -8'sd1, 1'b1);
      push_word(ACT_RECORD, 4'd1, 8'sd127, 1'b1);
      push_word(ACT_RECORD, 4'd1, -8'sd128, 1'b1);
      push_word(ACT_RECORD, 4'd1, -8'sd1, 1'b1);
      push_word(ACT_RECORD, 4'd12, 8'sd0, 1'b0);
      push_word(ACT_RECORD, 4'd12, -8'sd5, 1'b1);
      push_word(ACT_MONTH, 4'd1, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd12, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd0, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd13, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd15, -8'sd1, 1'b1);
      push_word(ACT_UNUSED, 4'd3, 8'sd44, 1'b1);
      push_word(ACT_UNUSED, 4'd15, -8'sd1, 1'b1);
      push_word(ACT_RECORD, 4'd6, 8'sd99, 1'b1);
      push_word(ACT_RECORD, 4'd7, -8'sd99, 1'b1);
      push_word(ACT_MONTH, 4'd6, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd7, 8'sd0, 1'b0);
      push_word(ACT_YEAR, 4'd0, 8'sd0, 1'b0);

      for (int i = 0; i < 1720; i++) begin
         r = $urandom_range(99);
         if (r < 70)
            push_word(ACT_RECORD, rnd_month(), rnd_temp(), $urandom_range(99) < 85,
                      i == 900);
         else if (r < 86)
            push_word(ACT_MONTH, ($urandom_range(9) == 0) ? MONTH_W'($urandom_range(15))
                                                          : rnd_month(),
                      rnd_temp(), 1'($urandom_range(1)), i == 900);
         else if (r < 95)
            push_word(ACT_YEAR, MONTH_W'($urandom_range(15)), rnd_temp(),
                      1'($urandom_range(1)), i == 900);
         else
            push_word(ACT_UNUSED, MONTH_W'($urandom_range(15)), rnd_temp(),
                      1'($urandom_range(1)), i == 900);
      end

      push_word(ACT_MONTH, 4'd9, 8'sd0, 1'b0);
      push_word(ACT_RECORD, 4'd9, 8'sd1, 1'b0);
      push_word(ACT_RECORD, 4'd9, 8'sd127, 1'b1);
      push_word(ACT_RECORD, 4'd9, -8'sd128, 1'b1);
      push_word(ACT_MONTH, 4'd9, 8'sd0, 1'b0);
      push_word(ACT_YEAR, 4'd0, 8'sd0, 1'b0);
      push_word(ACT_MONTH, 4'd3, 8'sd0, 1'b0);

      while (!(words_accepted == words_total && results_seen == reports_total))
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_reports.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== per_month_temperature_statistics_core.f =====
sv/pmts_pkg.sv
sv/pmts_ctrl.sv
sv/pmts_dp.sv
sv/per_month_temperature_statistics_core.sv
tb/testbench.sv
